/* src/bba_pkg.sv */
`timescale 1ns / 1ps
package bba_pkg;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int POOL_ORDER_DEF  = 8;
    localparam int PAGE_BYTES_DEF  = 4096;

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_ALLOC  = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NOFIT  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // controller -> datapath commands
    typedef struct packed {
        logic load;        // capture input item
        logic clr_table;   // entry_count <= 0, ready <= 0
        logic init_pool;   // append pool, ready <= 1
        logic scan_start;  // idx <= 0
        logic scan_next;   // idx++
        logic rd_issue;    // test read data of entry idx-1
        logic split_step;  // halve found entry, append upper (on a full table, write it back free)
        logic set_used;    // write found entry used
        logic take_buddy;  // absorb buddy (mark used, climb)
        logic append_cur;  // append merged block
        logic set_status;
        logic [1:0] status;
        logic set_addr;
        logic push_res;    // move result into the output register
    } bba_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       ready;
        logic       base_zero;
        logic       ord_bad;
        logic       free_bad;
        logic       scan_end;   // idx > entry_count, or table empty
        logic       hit;        // registered entry matches
        logic       need_split; // found order > req
        logic       full;       // table full
        logic       climb_ok;   // cur_ord < POOL_ORDER and buddy in range
    } bba_stat_t;
endpackage

/* src/bba_ram.sv */
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/bba_datapath.sv */
`timescale 1ns / 1ps
module bba_datapath import bba_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int POOL_ORDER  = POOL_ORDER_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] base_addr,
    input  logic [1:0]  in_cmd,
    input  logic [3:0]  in_order,
    input  logic [31:0] in_addr,
    input  bba_cmd_t    c,
    output bba_stat_t   s,
    output logic [31:0] res_addr,
    output logic [1:0]  res_status
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [3:0] PORD = 4'(POOL_ORDER);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam int EW = 37;

    logic [CW-1:0] count_reg;
    logic          ready_reg;
    logic [1:0]    cmd_reg;
    logic [3:0]    ord_reg;
    logic [31:0]   cur_reg;
    logic [3:0]    cur_ord_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [31:0]   hit_addr_reg;
    logic [3:0]    hit_ord_reg;
    logic [31:0]   addr_out_reg;
    logic [1:0]    st_out_reg;
    logic [31:0]   res_addr_reg;
    logic [1:0]    res_st_reg;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    bba_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    assign raddr = idx_reg[IW-1:0];

    function automatic logic [47:0] osize(input logic [3:0] o);
        osize = 48'(PAGE_BYTES) << o;
    endfunction

    logic [47:0] pool_bytes, off, boff;
    logic [47:0] upper_size;
    logic [31:0] buddy;
    logic [31:0] upper;
    assign pool_bytes = osize(PORD);
    assign off   = {16'd0, cur_reg - base_addr};
    assign boff  = off ^ osize(cur_ord_reg);
    assign buddy = base_addr + boff[31:0];
    assign upper_size = osize(hit_ord_reg - 4'd1);
    assign upper = hit_addr_reg + upper_size[31:0];

    // entry: {free, order, addr}
    logic r_free;
    logic [3:0] r_ord;
    logic [31:0] r_addr;
    assign {r_free, r_ord, r_addr} = rdata;

    logic match;
    always_comb begin
        if (cmd_reg == CMD_ALLOC) begin
            match = r_free && (r_ord >= ord_reg);
        end else begin
            match = r_free && (r_addr == buddy) && (r_ord == cur_ord_reg);
        end
    end

    logic hit_v_reg;
    logic full;
    assign full = (count_reg >= DEPTH_C);

    always_comb begin
        we = 1'b0;
        waddr = count_reg[IW-1:0];
        wdata = {1'b1, cur_ord_reg, cur_reg};
        if (c.init_pool) begin
            we = 1'b1;
            waddr = '0;
            wdata = {1'b1, PORD, base_addr};
        end else if (c.split_step) begin
            // upper half appended; on a full table the found entry goes back
            // free at its lowered order instead
            we = 1'b1;
            if (full) begin
                waddr = hit_idx_reg;
                wdata = {1'b1, hit_ord_reg - 4'd1, hit_addr_reg};
            end else begin
                waddr = count_reg[IW-1:0];
                wdata = {1'b1, hit_ord_reg - 4'd1, upper};
            end
        end else if (c.set_used) begin
            we = 1'b1;
            waddr = hit_idx_reg;
            wdata = {1'b0, hit_ord_reg, hit_addr_reg};
        end else if (c.take_buddy) begin
            we = 1'b1;
            waddr = hit_idx_reg;
            wdata = {1'b0, cur_ord_reg, buddy};
        end else if (c.append_cur) begin
            we = !full;
        end
    end

    // The split writes only the upper half; the found entry is rewritten once
    // at the end (used, or free at its cut order when the table fills).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ready_reg <= 1'b0;
        end else begin
            if (c.clr_table) begin
                count_reg <= '0;
                ready_reg <= 1'b0;
            end
            if (c.init_pool) begin
                count_reg <= CW'(1);
                ready_reg <= 1'b1;
            end
            if ((c.split_step || c.append_cur) && !full) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c.load) begin
            cmd_reg <= in_cmd;
            ord_reg <= in_order;
            cur_reg <= in_addr;
            cur_ord_reg <= in_order;
        end
        if (c.scan_start) begin
            idx_reg <= '0;
            hit_v_reg <= 1'b0;
        end else if (c.scan_next) begin
            idx_reg <= idx_reg + CW'(1);
        end
        // read data is valid only while idx is nonzero; it then holds entry idx-1
        if (c.rd_issue && (idx_reg != '0)) begin
            hit_v_reg <= match;
            if (match) begin
                hit_idx_reg <= IW'(idx_reg - CW'(1));
                hit_addr_reg <= r_addr;
                hit_ord_reg <= r_ord;
            end
        end
        if (c.split_step) begin
            hit_ord_reg <= hit_ord_reg - 4'd1;
        end
        if (c.take_buddy) begin
            if (boff < off) begin
                cur_reg <= buddy;
            end
            cur_ord_reg <= cur_ord_reg + 4'd1;
        end
        if (c.set_status) begin
            st_out_reg <= c.status;
            addr_out_reg <= c.set_addr ? hit_addr_reg : 32'd0;
        end
        if (c.push_res) begin
            res_st_reg <= st_out_reg;
            res_addr_reg <= addr_out_reg;
        end
    end

    logic in_pool;
    assign in_pool = (cur_reg >= base_addr) && (off < pool_bytes);

    assign s.cmd        = cmd_reg;
    assign s.ready      = ready_reg;
    assign s.base_zero  = (base_addr == 32'd0);
    assign s.ord_bad    = (ord_reg > PORD);
    assign s.free_bad   = !in_pool;
    assign s.scan_end   = (idx_reg > count_reg) || (count_reg == '0);
    assign s.hit        = hit_v_reg;
    assign s.need_split = (hit_ord_reg > ord_reg);
    assign s.full       = full;
    assign s.climb_ok   = (cur_ord_reg < PORD) && (cur_reg >= base_addr)
                          && (boff < pool_bytes);
    assign res_addr   = res_addr_reg;
    assign res_status = res_st_reg;
endmodule

/* src/bba_ctrl.sv */
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  bba_stat_t s,
    output bba_cmd_t  c
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_SPLIT, S_CHECK, S_DONE
    } state_t;
    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    // Scan: idx steps each cycle until a hit or the scan end; read data of idx-1 is tested with rd_issue.
    always_comb begin
        c = '0;
        state_next = state_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    c.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                c.status = ST_REJECT;
                if (s.cmd == CMD_INIT) begin
                    c.clr_table = 1'b1;
                    c.init_pool = !s.base_zero;
                    c.status = s.base_zero ? ST_REJECT : ST_OK;
                    c.set_status = 1'b1;
                    state_next = S_DONE;
                end else if (!s.ready || s.ord_bad || s.cmd == CMD_UNUSED ||
                             (s.cmd == CMD_FREE && s.free_bad)) begin
                    c.set_status = 1'b1;
                    state_next = S_DONE;
                end else if (s.cmd == CMD_FREE && !s.climb_ok) begin
                    c.append_cur = 1'b1;
                    c.status = s.full ? ST_FULL : ST_OK;
                    c.set_status = 1'b1;
                    state_next = S_DONE;
                end else begin
                    c.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                c.rd_issue = 1'b1;
                c.scan_next = 1'b1;
                if (s.hit) begin
                    c.scan_next = 1'b0;
                    c.rd_issue = 1'b0;
                    if (s.cmd == CMD_ALLOC) begin
                        state_next = S_SPLIT;
                    end else begin
                        c.take_buddy = 1'b1;
                        state_next = S_CHECK;
                    end
                end else if (s.scan_end) begin
                    c.rd_issue = 1'b0;
                    c.scan_next = 1'b0;
                    c.set_status = 1'b1;
                    if (s.cmd == CMD_ALLOC) begin
                        c.status = ST_NOFIT;
                    end else begin
                        c.append_cur = 1'b1;
                        c.status = s.full ? ST_FULL : ST_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_SPLIT: begin
                if (s.need_split && !s.full) begin
                    c.split_step = 1'b1;
                end else if (s.need_split) begin
                    // table full: found entry written back free at its cut order
                    c.split_step = 1'b1;
                    c.set_status = 1'b1;
                    c.status = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    c.set_used = 1'b1;
                    c.set_status = 1'b1;
                    c.set_addr = 1'b1;
                    c.status = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_CHECK: begin
                if (s.climb_ok) begin
                    c.scan_start = 1'b1;
                    state_next = S_SCAN;
                end else begin
                    c.append_cur = 1'b1;
                    c.set_status = 1'b1;
                    c.status = s.full ? ST_FULL : ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!valid_reg || out_ready) begin
                    c.push_res = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
endmodule

/* src/buddy_block_allocator_top.sv */
`timescale 1ns / 1ps
// Steps: init and rejected items go from decode straight to the done state;
//   alloc scans the table once, then halves the found block one order per split
//   step; free scans for the buddy once per merge level, with a check in between.
//   Scans read one table entry per cycle (registered RAM) until a hit or the end.
// Throughput: one command at a time; the next item is taken the cycle after the
//   result moves to the output register. Reset (aresetn low, synchronous)
//   empties the table count, clears pool ready and output valid; RAM not cleared.
module buddy_block_allocator_top import bba_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int POOL_ORDER  = POOL_ORDER_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[1:0], req_order[5:2], free_addr[37:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // block_addr[31:0], status[33:32]
);
    logic [31:0] base_addr_reg;
    bba_cmd_t    c;
    bba_stat_t   s;
    logic [31:0] res_addr;
    logic [1:0]  res_status;
    logic        in_fire;

    assign pready = 1'b1;
    assign prdata = base_addr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= 32'd0;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            base_addr_reg <= pwdata;
        end
    end

    assign in_fire = s_tvalid && s_tready;

    bba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .s(s), .c(c)
    );

    bba_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH), .POOL_ORDER(POOL_ORDER), .PAGE_BYTES(PAGE_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .base_addr(base_addr_reg),
        .in_cmd(s_tdata[1:0]), .in_order(s_tdata[5:2]), .in_addr(s_tdata[37:6]),
        .c(c), .s(s), .res_addr(res_addr), .res_status(res_status)
    );

    assign m_tdata = {6'd0, res_status, res_addr};

    // a stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ok_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == 32'd0)
        else $error("address on failed command");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("took two items");
endmodule
